>>> rtl/matrix_power_column_dominance_assert.svh
// assertion macros used by the top rtl file
`ifndef MATRIX_POWER_COLUMN_DOMINANCE_ASSERT_SVH
`define MATRIX_POWER_COLUMN_DOMINANCE_ASSERT_SVH
// implication checked at every rising edge outside reset
`define MPCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MPCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/mpcd_pkg.sv
// ---------------------------------------------------------------------------
// mpcd_pkg: shared types and constants
// column dominance of matrix powers, Q16.16 fixed point
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package mpcd_pkg;
  localparam int MaxSize   = 16;
  localparam int IdxBits   = $clog2(MaxSize);
  localparam int AddrBits  = 2 * IdxBits;
  localparam int ValueBits = 32;
  localparam int FracBits  = 16;
  localparam int SumBits   = (ValueBits + 8 < 64) ? ValueBits + 8 : 64;
  localparam int ProdBits  = 2 * ValueBits;

  localparam logic [1:0] CfgSize   = 2'd0;
  localparam logic [1:0] CfgFirst  = 2'd1;
  localparam logic [1:0] CfgSecond = 2'd2;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncStart = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic signed [31:0] entry_value;
  } in_beat_t;

  typedef struct packed {
    logic       dominated;
    logic [4:0] deciding_round;
    logic       saturated;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COPY, ST_SUM_A, ST_SUM_B, ST_DECIDE, ST_MAC,
    ST_MUL, ST_ACC, ST_WB, ST_MOVE, ST_DONE
  } state_t;

  // multiplier request/response between sequencer and unit
  typedef struct packed {
    logic                        go;
    logic signed [ValueBits-1:0] x;
    logic signed [ValueBits-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] q;
    logic                        sat;
  } mul_rsp_t;
endpackage

>>> rtl/mpcd_mul.sv
// ---------------------------------------------------------------------------
// mpcd_mul: shared Q16.16 multiplier
// one registered product, then truncate toward minus infinity and saturate
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mpcd_mul (
  input  logic              clk,
  input  mpcd_pkg::mul_req_t req,
  output mpcd_pkg::mul_rsp_t rsp
);
  logic signed [mpcd_pkg::ProdBits-1:0] prod_r;
  logic signed [mpcd_pkg::ProdBits-1:0] shf;
  localparam logic signed [mpcd_pkg::ProdBits-1:0] Top =
    mpcd_pkg::ProdBits'((64'sd1 <<< (mpcd_pkg::ValueBits - 1)) - 64'sd1);
  localparam logic signed [mpcd_pkg::ProdBits-1:0] Bot = -Top - 1;

  // product register
  always_ff @(posedge clk) begin
    if (req.go) prod_r <= req.x * req.y;
  end

  // arithmetic shift floors, then clamp
  always_comb begin
    shf = prod_r >>> mpcd_pkg::FracBits;
    rsp.sat = 1'b0;
    if (shf > Top) begin
      rsp.q = Top[mpcd_pkg::ValueBits-1:0]; rsp.sat = 1'b1;
    end else if (shf < Bot) begin
      rsp.q = Bot[mpcd_pkg::ValueBits-1:0]; rsp.sat = 1'b1;
    end else begin
      rsp.q = shf[mpcd_pkg::ValueBits-1:0];
    end
  end
endmodule

>>> rtl/matrix_power_column_dominance.sv
// ---------------------------------------------------------------------------
// matrix_power_column_dominance: column dominance of matrix powers
// loads F entry by entry, start runs up to 2n-1 rounds of column sums
// ---------------------------------------------------------------------------
// a start copies F into P, then each round takes both column sums and the
// decision, then P times F and the move of the product into P, and a result
// beat ends the run; all through one shared multiplier and one accumulator;
// one item at a time
// reset: synchronous, active low; registers return to n=16, a=0, b=1;
// matrix memories are undefined until written
`timescale 1ns / 1ps
`include "matrix_power_column_dominance_assert.svh"
module matrix_power_column_dominance (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpcd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mpcd_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data
);
  localparam int IB = mpcd_pkg::IdxBits;
  localparam int AB = mpcd_pkg::AddrBits;
  localparam int VB = mpcd_pkg::ValueBits;
  localparam int SB = mpcd_pkg::SumBits;
  localparam logic signed [VB:0] VTop = (VB+1)'((65'sd1 <<< (VB-1)) - 65'sd1);
  localparam logic signed [VB:0] VBot = -VTop - 1;
  localparam logic signed [SB:0] STop = (SB+1)'((65'sd1 <<< (SB-1)) - 65'sd1);
  localparam logic signed [SB:0] SBot = -STop - 1;

  // memories
  logic signed [VB-1:0] base_mem [2**AB];
  logic signed [VB-1:0] pow_mem  [2**AB];
  logic signed [VB-1:0] nxt_mem  [2**AB];
  logic signed [VB-1:0] base_q_r, pow_q_r, nxt_q_r;

  mpcd_pkg::state_t state_r, state_nxt;
  logic [4:0] size_r, size_nxt;
  logic [3:0] cola_r, cola_nxt, colb_r, colb_nxt;
  logic [IB:0] n_w;
  logic [IB-1:0] nm1;
  logic [IB-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [4:0] round_r, round_nxt;
  logic [5:0] rounds_w;
  logic signed [SB-1:0] suma_r, suma_nxt, sumb_r, sumb_nxt;
  logic signed [VB-1:0] acc_r, acc_nxt;
  logic sat_r, sat_nxt, dom_r, dom_nxt, ov_r, ov_nxt;
  logic [5:0] rcnt_r, rcnt_nxt;
  mpcd_pkg::out_beat_t res_r, res_nxt;

  // memory control
  logic [AB-1:0] base_ra, pow_ra, nxt_ra, pow_wa, nxt_wa;
  logic pow_we, nxt_we;
  logic signed [VB-1:0] pow_wd;
  logic signed [SB:0] sadd;
  logic signed [VB:0] vadd;
  logic [3:0] col_sel;

  mpcd_pkg::mul_req_t mreq;
  mpcd_pkg::mul_rsp_t mrsp;
  mpcd_mul u_mul (.clk(clk), .req(mreq), .rsp(mrsp));

  assign n_w = (size_r == 5'd0) ? (IB+1)'(1) :
               (size_r > 5'(mpcd_pkg::MaxSize)) ? (IB+1)'(mpcd_pkg::MaxSize) :
               size_r[IB:0];
  assign nm1 = IB'(n_w - 1'b1);
  assign rounds_w = {n_w, 1'b0} - 6'd1;
  assign in_ready = (state_r == mpcd_pkg::ST_IDLE);
  assign out_data = res_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.func == mpcd_pkg::FuncWrite)
      base_mem[{in_data.row_index, in_data.col_index}] <= in_data.entry_value;
    if (pow_we) pow_mem[pow_wa] <= pow_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= acc_r;
    base_q_r <= base_mem[base_ra];
    pow_q_r  <= pow_mem[pow_ra];
    nxt_q_r  <= nxt_mem[nxt_ra];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpcd_pkg::ST_IDLE;
      size_r <= 5'd16; cola_r <= 4'd0; colb_r <= 4'd1;
      round_r <= '0; suma_r <= '0; sumb_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r <= size_nxt; cola_r <= cola_nxt; colb_r <= colb_nxt;
      round_r <= round_nxt; suma_r <= suma_nxt; sumb_r <= sumb_nxt;
      if (state_r == mpcd_pkg::ST_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; acc_r <= acc_nxt;
    sat_r <= sat_nxt; dom_r <= dom_nxt; ov_r <= ov_nxt; rcnt_r <= rcnt_nxt;
    res_r <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    size_nxt = size_r; cola_nxt = cola_r; colb_nxt = colb_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; acc_nxt = acc_r;
    round_nxt = round_r; rcnt_nxt = rcnt_r;
    suma_nxt = suma_r; sumb_nxt = sumb_r;
    sat_nxt = sat_r; dom_nxt = dom_r; ov_nxt = ov_r; res_nxt = res_r;
    base_ra = {i_r, j_r}; pow_ra = {i_r, j_r}; nxt_ra = {i_r, j_r};
    pow_we = 1'b0; pow_wa = {i_r, j_r}; pow_wd = base_q_r;
    nxt_we = 1'b0; nxt_wa = {i_r, j_r};
    mreq.go = 1'b0; mreq.x = pow_q_r; mreq.y = base_q_r;
    col_sel = (state_r == mpcd_pkg::ST_SUM_A) ? cola_r : colb_r;
    sadd = '0; vadd = '0;
    if (cfg_we) begin
      unique case (cfg_index)
        mpcd_pkg::CfgSize:   size_nxt = cfg_data;
        mpcd_pkg::CfgFirst:  cola_nxt = cfg_data[3:0];
        mpcd_pkg::CfgSecond: colb_nxt = cfg_data[3:0];
        default: ;
      endcase
    end
    unique case (state_r)
      mpcd_pkg::ST_IDLE: begin
        i_nxt = '0; j_nxt = '0; ov_nxt = 1'b0;
        if (in_valid && in_data.func == mpcd_pkg::FuncStart) begin
          state_nxt = mpcd_pkg::ST_COPY; sat_nxt = 1'b0; dom_nxt = 1'b0;
          rcnt_nxt = 6'd1; ov_nxt = 1'b0;
        end
      end
      // copy F into P; ov_r marks a read in flight whose entry is written now
      mpcd_pkg::ST_COPY: begin
        base_ra = {i_r, j_r};
        pow_wa = {i_nxt, j_nxt};
        if (ov_r) begin
          pow_we = 1'b1;
          pow_wa = (j_r == '0) ? {((i_r == '0) ? nm1 : IB'(i_r - 1'b1)), nm1}
                               : {i_r, IB'(j_r - 1'b1)};
        end
        if (ov_r && i_r == '0 && j_r == '0) begin
          state_nxt = mpcd_pkg::ST_SUM_A; i_nxt = '0; ov_nxt = 1'b0;
          suma_nxt = '0;
        end else if (j_r == nm1) begin
          j_nxt = '0; i_nxt = (i_r == nm1) ? '0 : IB'(i_r + 1'b1); ov_nxt = 1'b1;
        end else begin
          j_nxt = IB'(j_r + 1'b1); ov_nxt = 1'b1;
        end
      end
      // column sums, one row per cycle after a read cycle
      mpcd_pkg::ST_SUM_A, mpcd_pkg::ST_SUM_B: begin
        pow_ra = {i_r, col_sel[IB-1:0]};
        if (ov_r) begin
          sadd = (state_r == mpcd_pkg::ST_SUM_A ? {suma_r[SB-1], suma_r}
                                                : {sumb_r[SB-1], sumb_r})
                 + (SB+1)'(pow_q_r);
          if (sadd > STop) begin sadd = STop; sat_nxt = 1'b1; end
          else if (sadd < SBot) begin sadd = SBot; sat_nxt = 1'b1; end
          if ((IB+1)'(col_sel) >= n_w) sadd = '0;
          if (state_r == mpcd_pkg::ST_SUM_A) suma_nxt = sadd[SB-1:0];
          else sumb_nxt = sadd[SB-1:0];
        end
        ov_nxt = 1'b1;
        if (ov_r && i_r == '0) begin
          ov_nxt = 1'b0;
          if (state_r == mpcd_pkg::ST_SUM_A) begin
            state_nxt = mpcd_pkg::ST_SUM_B; sumb_nxt = '0;
          end else state_nxt = mpcd_pkg::ST_DECIDE;
        end else i_nxt = (i_r == nm1) ? '0 : IB'(i_r + 1'b1);
        if (!ov_r && state_r == mpcd_pkg::ST_SUM_A) round_nxt = rcnt_r[4:0];
      end
      mpcd_pkg::ST_DECIDE: begin
        i_nxt = '0; j_nxt = '0; k_nxt = '0; acc_nxt = '0;
        if ((rcnt_r[0] && suma_r < sumb_r) || (!rcnt_r[0] && sumb_r < suma_r)) begin
          dom_nxt = 1'b1; state_nxt = mpcd_pkg::ST_DONE;
        end else if (suma_r != sumb_r) begin
          state_nxt = mpcd_pkg::ST_DONE;
        end else if (rcnt_r == rounds_w) begin
          state_nxt = mpcd_pkg::ST_DONE;
        end else state_nxt = mpcd_pkg::ST_MAC;
      end
      // issue reads of P[i][k] and F[k][j]
      mpcd_pkg::ST_MAC: begin
        pow_ra = {i_r, k_r}; base_ra = {k_r, j_r};
        state_nxt = mpcd_pkg::ST_MUL;
      end
      mpcd_pkg::ST_MUL: begin
        mreq.go = 1'b1; state_nxt = mpcd_pkg::ST_ACC;
      end
      mpcd_pkg::ST_ACC: begin
        vadd = {acc_r[VB-1], acc_r} + {mrsp.q[VB-1], mrsp.q};
        if (mrsp.sat) sat_nxt = 1'b1;
        if (vadd > VTop) begin vadd = VTop; sat_nxt = 1'b1; end
        else if (vadd < VBot) begin vadd = VBot; sat_nxt = 1'b1; end
        acc_nxt = vadd[VB-1:0];
        if (k_r == nm1) state_nxt = mpcd_pkg::ST_WB;
        else begin k_nxt = IB'(k_r + 1'b1); state_nxt = mpcd_pkg::ST_MAC; end
      end
      mpcd_pkg::ST_WB: begin
        nxt_we = 1'b1; acc_nxt = acc_r; k_nxt = '0;
        state_nxt = mpcd_pkg::ST_MAC;
        if (j_r == nm1) begin
          j_nxt = '0;
          if (i_r == nm1) begin
            i_nxt = '0; state_nxt = mpcd_pkg::ST_MOVE; ov_nxt = 1'b0;
          end else i_nxt = IB'(i_r + 1'b1);
        end else j_nxt = IB'(j_r + 1'b1);
      end
      // copy next into power
      mpcd_pkg::ST_MOVE: begin
        nxt_ra = {i_r, j_r};
        if (ov_r) begin
          pow_we = 1'b1; pow_wd = nxt_q_r;
          pow_wa = (j_r == '0) ? {((i_r == '0) ? nm1 : IB'(i_r - 1'b1)), nm1}
                               : {i_r, IB'(j_r - 1'b1)};
        end
        if (ov_r && i_r == '0 && j_r == '0) begin
          state_nxt = mpcd_pkg::ST_SUM_A; ov_nxt = 1'b0; suma_nxt = '0;
          rcnt_nxt = rcnt_r + 6'd1;
        end else if (j_r == nm1) begin
          j_nxt = '0; i_nxt = (i_r == nm1) ? '0 : IB'(i_r + 1'b1); ov_nxt = 1'b1;
        end else begin
          j_nxt = IB'(j_r + 1'b1); ov_nxt = 1'b1;
        end
      end
      // load the result register once the previous beat has left
      mpcd_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          res_nxt.dominated = dom_r; res_nxt.saturated = sat_r;
          res_nxt.deciding_round = (suma_r != sumb_r) ? rcnt_r[4:0] : 5'd0;
          state_nxt = mpcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpcd_pkg::ST_IDLE;
    endcase
    // the acc is cleared after write-back
    if (state_r == mpcd_pkg::ST_WB) acc_nxt = '0;
    nxt_wa = {i_r, j_r};
  end

  // write-back uses the accumulator before clearing
  // (nxt memory takes acc_r in that state)
  // checks
  `MPCD_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_ready, state_r == mpcd_pkg::ST_IDLE)
  `MPCD_ASSERT_NXT(a_done_valid, clk, rst_n, state_r == mpcd_pkg::ST_DONE, out_valid)
  `MPCD_ASSERT_IMP(a_no_wr_busy, clk, rst_n, pow_we, state_r == mpcd_pkg::ST_COPY || state_r == mpcd_pkg::ST_MOVE)
  `MPCD_ASSERT_IMP(a_round_lim, clk, rst_n, state_r == mpcd_pkg::ST_DECIDE, rcnt_r <= rounds_w)
endmodule

>>> tb/mpcd_checker.sv
// ---------------------------------------------------------------------------
// mpcd_checker: result predictor and scoreboard
// mirrors register writes and matrix loads, predicts one result per start
// beat and compares each accepted result beat field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mpcd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mpcd_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mpcd_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  output int                  pending,
  output int                  fail_count
);
  // shadow registers and matrices
  logic [4:0] dim_reg;
  logic [3:0] col_a_reg;
  logic [3:0] col_b_reg;
  longint     base_m  [mpcd_pkg::MaxSize*mpcd_pkg::MaxSize];
  longint     power_m [mpcd_pkg::MaxSize*mpcd_pkg::MaxSize];
  longint     next_m  [mpcd_pkg::MaxSize*mpcd_pkg::MaxSize];
  bit         run_sat;
  mpcd_pkg::out_beat_t verdicts_q[$];

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      run_sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      run_sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // q16.16 product, floor of the shifted product, then saturated
  function automatic longint fx_mul(longint x, longint y);
    longint p;
    p = x * y;
    return clamp_bits(p >>> mpcd_pkg::FracBits, mpcd_pkg::ValueBits);
  endfunction

  function automatic longint column_sum(int unsigned col, int unsigned n);
    longint s;
    s = 0;
    if (col >= n) return 0;
    for (int unsigned r = 0; r < n; r++)
      s = clamp_bits(s + power_m[r*mpcd_pkg::MaxSize + col], mpcd_pkg::SumBits);
    return s;
  endfunction

  function automatic void step_power(int unsigned n);
    longint acc;
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < n; j++) begin
        acc = 0;
        for (int unsigned k = 0; k < n; k++)
          acc = clamp_bits(acc + fx_mul(power_m[i*mpcd_pkg::MaxSize + k],
                                        base_m[k*mpcd_pkg::MaxSize + j]),
                           mpcd_pkg::ValueBits);
        next_m[i*mpcd_pkg::MaxSize + j] = acc;
      end
    power_m = next_m;
  endfunction

  function automatic mpcd_pkg::out_beat_t predict_dominance();
    int unsigned n;
    int unsigned rounds;
    int unsigned decided;
    bit          dom;
    longint      sa;
    longint      sb;
    mpcd_pkg::out_beat_t res;
    n = dim_reg;
    if (n < 1) n = 1;
    if (n > mpcd_pkg::MaxSize) n = mpcd_pkg::MaxSize;
    run_sat = 1'b0;
    dom     = 1'b0;
    decided = 0;
    power_m = base_m;
    rounds  = 2*n - 1;
    for (int unsigned r = 1; r <= rounds; r++) begin
      sa = column_sum(col_a_reg, n);
      sb = column_sum(col_b_reg, n);
      if ((r[0] && sa < sb) || (!r[0] && sb < sa)) begin
        dom = 1'b1;
        decided = r;
        break;
      end
      if (sa != sb) begin
        decided = r;
        break;
      end
      if (r < rounds) step_power(n);
    end
    res.dominated      = dom;
    res.deciding_round = decided[4:0];
    res.saturated      = run_sat;
    return res;
  endfunction

  // watch the three ports
  always @(posedge clk) begin
    mpcd_pkg::out_beat_t exp_beat;
    int errs;
    errs = 0;
    if (!rst_n) begin
      dim_reg    <= 5'd16;
      col_a_reg  <= 4'd0;
      col_b_reg  <= 4'd1;
      fail_count <= 0;
      pending    <= 0;
      verdicts_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mpcd_pkg::CfgSize:   dim_reg   <= cfg_data;
          mpcd_pkg::CfgFirst:  col_a_reg <= cfg_data[3:0];
          mpcd_pkg::CfgSecond: col_b_reg <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.func == mpcd_pkg::FuncWrite)
          base_m[in_data.row_index*mpcd_pkg::MaxSize + in_data.col_index] =
            longint'(in_data.entry_value);
        else
          verdicts_q.push_back(predict_dominance());
      end
      if (out_valid && out_ready) begin
        if (verdicts_q.size() == 0) begin
          $error("result beat with no start pending: %p", out_data);
          errs++;
        end else begin
          exp_beat = verdicts_q.pop_front();
          if (out_data.dominated !== exp_beat.dominated) begin
            $error("dominated: expected %0d actual %0d",
                   exp_beat.dominated, out_data.dominated);
            errs++;
          end
          if (out_data.deciding_round !== exp_beat.deciding_round) begin
            $error("deciding_round: expected %0d actual %0d",
                   exp_beat.deciding_round, out_data.deciding_round);
            errs++;
          end
          if (out_data.saturated !== exp_beat.saturated) begin
            $error("saturated: expected %0d actual %0d",
                   exp_beat.saturated, out_data.saturated);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= verdicts_q.size();
    end
  end
endmodule

>>> tb/tb_matrix_power_column_dominance.sv
// ---------------------------------------------------------------------------
// tb_matrix_power_column_dominance: stimulus and verdict
// loads the whole matrix, runs directed starts over register extremes, then
// random phases of small matrices with equal-sum columns, random entries and
// stray writes; the sender bursts and the receiver stalls throughout
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_matrix_power_column_dominance;
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int         ItemGoal  = 1750;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mpcd_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mpcd_pkg::out_beat_t out_data;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [4:0]          cfg_data;
  int                  pending;
  int                  fail_count;
  int                  beats_sent;
  int                  burst_left;

  matrix_power_column_dominance dut (.*);

  mpcd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500_000_000;
    $display("FAIL matrix_power_column_dominance");
    $finish;
  end

  // receiver stall pattern in stretches, each with a randomly drawn mode
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // one beat, then maybe a gap at the end of a burst
  task automatic send_beat(logic func, int row, int col, logic [31:0] value);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data.func        <= func;
    in_data.row_index   <= row[3:0];
    in_data.col_index   <= col[3:0];
    in_data.entry_value <= value;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic write_entry(int row, int col, logic [31:0] value);
    send_beat(mpcd_pkg::FuncWrite, row, col, value);
  endtask

  task automatic start_check();
    send_beat(mpcd_pkg::FuncStart, $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom);
  endtask

  // wait for every outstanding result, then let a write beat settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[4:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_regs(int n, int a, int b);
    drain();
    set_reg(mpcd_pkg::CfgSize, n);
    set_reg(mpcd_pkg::CfgFirst, a);
    set_reg(mpcd_pkg::CfgSecond, b);
  endtask

  // small whole or fractional value, powers of it grow toward saturation
  function automatic logic [31:0] small_value(bit frac);
    int v;
    v = $urandom_range(0, 4) - 2;
    return frac ? (v <<< 16) + $urandom_range(0, 65535) : (v <<< 16);
  endfunction

  // load an n-by-n block; column b mirrors column a in some patterns
  task automatic load_block(int n, int a, int b, int kind);
    logic [31:0] col_a [mpcd_pkg::MaxSize];
    logic [31:0] v;
    for (int r = 0; r < n; r++) col_a[r] = small_value(kind == 2);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (kind == 0) v = $urandom;
        else if (c == a) v = col_a[r];
        else if (c == b && $urandom_range(0, 5) != 0) v = col_a[(r + kind) % n];
        else v = small_value(kind == 2);
        write_entry(r, c, v);
      end
  endtask

  initial begin
    int n;
    int a;
    int b;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = mpcd_pkg::CfgSize;
    cfg_data   = '0;
    beats_sent = 0;
    burst_left = 8;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // whole matrix loaded so that no start reads an unwritten entry
    for (int r = 0; r < mpcd_pkg::MaxSize; r++)
      for (int c = 0; c < mpcd_pkg::MaxSize; c++)
        write_entry(r, c, $urandom);

    // directed: reset registers, full size
    start_check();
    // size zero acts as one, identical columns use up the only round
    set_regs(0, 0, 0);
    start_check();
    // column beyond the size sums to zero
    set_regs(1, 0, 5);
    start_check();
    drain();
    set_reg(CfgUnused, 31);
    start_check();
    // extreme entries, product saturation
    set_regs(2, 0, 1);
    write_entry(0, 0, 32'h7fff_ffff);
    write_entry(0, 1, 32'h8000_0000);
    write_entry(1, 0, 32'h8000_0000);
    write_entry(1, 1, 32'h7fff_ffff);
    start_check();
    write_entry(1, 0, 32'h7fff_ffff);
    write_entry(0, 1, 32'h7fff_ffff);
    start_check();
    // size above the maximum acts as the maximum
    set_regs(31, 15, 14);
    start_check();
    // equal columns at full size run every round with no product after the last
    set_regs(16, 3, 3);
    start_check();
    // equal sums but different columns, later rounds decide
    set_regs(3, 0, 2);
    load_block(3, 0, 2, 1);
    start_check();

    // random phases
    while (beats_sent < ItemGoal) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
      b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
      set_regs(n, a, b);
      repeat ($urandom_range(1, 4)) begin
        load_block(n, a, b, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2));
        // stray writes anywhere in the matrix
        repeat ($urandom_range(0, 3))
          write_entry($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        repeat ($urandom_range(1, 2)) start_check();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    if (fail_count == 0)
      $display("PASS matrix_power_column_dominance");
    else
      $display("FAIL matrix_power_column_dominance");
    $finish;
  end
endmodule

>>> matrix_power_column_dominance.f
+incdir+rtl
rtl/mpcd_pkg.sv
rtl/mpcd_mul.sv
rtl/matrix_power_column_dominance.sv
tb/mpcd_checker.sv
tb/tb_matrix_power_column_dominance.sv
